@@ hw/rtl/sor_pkg.sv @@
// sor_pkg: shared constants and types for the sigma outlier rejection core
// holds register indexes, reset values, multiplier digit width and the status struct
// no dependencies
package sor_pkg;

   // configuration register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_WINDOW_SIZE  = 2'd0;
   localparam csr_index_type CSR_REJECT_LIMIT = 2'd1;

   // register field widths and reset values
   localparam int WINDOW_CFG_W = 7;
   localparam int LIMIT_W      = 8;
   localparam int WINDOW_RESET = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd48;

   // square of the Q4.4 limit, and the matching scale on the deviation side
   localparam int K2_W      = 2 * LIMIT_W;
   localparam int VAR_SHIFT = 8;

   // fewest held samples before the test applies
   localparam int MIN_HELD = 3;

   // multiplier digit consumed per cycle
   localparam int MUL_DIGIT_W = 16;

   // shared multiplier status
   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

@@ hw/rtl/sor_mul_unit.sv @@
// sor_mul_unit: shared iterative unsigned multiplier, one 16-bit digit of b per cycle
// stops early once the remaining digits of b are zero; product holds until the next start
// depends on sor_pkg
module sor_mul_unit #(
   parameter int A_W = 44,
   parameter int B_W = 23,
   parameter int P_W = 60
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [A_W-1:0]         a,
   input  logic [B_W-1:0]         b,
   output sor_pkg::mul_status_type status,
   output logic [P_W-1:0]         product
);

   localparam int D     = sor_pkg::MUL_DIGIT_W;
   localparam int NDIG  = (B_W + D - 1) / D;
   localparam int B_PAD = NDIG * D;

   logic [P_W-1:0]   mcand_ff, mcand_in;
   logic [B_PAD-1:0] mplier_ff, mplier_in;
   logic [P_W-1:0]   acc_ff, acc_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [D-1:0]     digit;
   logic [P_W+D-1:0] partial;
   logic [B_PAD-1:0] mplier_next;

   // one digit step
   always_comb begin
      digit       = mplier_ff[D-1:0];
      partial     = mcand_ff * digit;
      mplier_next = mplier_ff >> D;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      acc_in      = acc_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      if (start) begin
         mcand_in  = P_W'(a);
         mplier_in = B_PAD'(b);
         acc_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = acc_ff + partial[P_W-1:0];
         mcand_in  = mcand_ff << D;
         mplier_in = mplier_next;
         if (mplier_next == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operand and accumulator registers
   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

@@ hw/rtl/sigma_outlier_rejection_core.sv @@
// sigma_outlier_rejection_core: top level, sequencer, window state and sample ring
// depends on sor_pkg and sor_mul_unit
//
// Sliding-window sigma outlier filter. Each accepted sample x is tested against the
// window of kept samples (sum S, sum of squares Q, count n) as
// 256*(n*x - S)^2 > k^2*(n*Q - S^2), k = reject_limit in Q4.4; an outlier returns the
// newest kept sample with rejected set, any other sample is stored and passed through.
// All products run through one shared multiplier that takes 16 bits of its second
// operand per cycle and stops after the highest nonzero 16-bit digit of that operand
// (at least one). With fewer than three samples held an item needs only the square of
// x and, on eviction, of the oldest sample; a tested item runs up to eight products in
// series, and its result may wait for the output register. req_ready is high only
// when the sequencer is idle; a finished result waits in the output register while the
// next sample is already being worked on. Writing window_size clears the window; the
// sample ring needs no clearing pass, since only slots written since the last clear are read.
module sigma_outlier_rejection_core #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_filtered,
   output logic                                 rsp_rejected,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  sor_pkg::csr_index_type               csr_index,
   input  logic [sor_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // derived widths
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int ADDR_W  = $clog2(MAX_WINDOW);
   localparam int SUM_W   = SAMPLE_BITS + ADDR_W;
   localparam int SQ_W    = 2 * SAMPLE_BITS - 1 + ADDR_W;
   localparam int XSQ_W   = 2 * SAMPLE_BITS - 1;
   localparam int MAG_W   = SUM_W + 1;
   localparam int DIFF_W  = SUM_W + 2;
   localparam int NQ_W    = SQ_W + CNT_W;
   localparam int LHS_W   = 2 * MAG_W + sor_pkg::VAR_SHIFT;
   localparam int RHS_W   = NQ_W + sor_pkg::K2_W;
   localparam int A_W     = NQ_W;
   localparam int B_W     = (MAG_W > sor_pkg::K2_W) ? MAG_W : sor_pkg::K2_W;
   localparam int P_W     = (RHS_W > 2 * MAG_W) ? RHS_W : 2 * MAG_W;
   localparam int CMP_W   = (LHS_W > P_W) ? LHS_W : P_W;
   localparam int OFS_W   = CNT_W + 1;
   localparam int WCMP_W  = (CNT_W > sor_pkg::WINDOW_CFG_W) ? CNT_W : sor_pkg::WINDOW_CFG_W;
   localparam int WINDOW_INIT =
      (sor_pkg::WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : sor_pkg::WINDOW_RESET;

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_NX   = 4'd1;
   localparam logic [3:0] ST_DM2  = 4'd2;
   localparam logic [3:0] ST_NQ   = 4'd3;
   localparam logic [3:0] ST_S2   = 4'd4;
   localparam logic [3:0] ST_K2   = 4'd5;
   localparam logic [3:0] ST_VK   = 4'd6;
   localparam logic [3:0] ST_XX   = 4'd7;
   localparam logic [3:0] ST_OV   = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;

   // control registers
   logic [3:0]                     state_ff, state_in;
   logic                           launch_ff, launch_in;
   logic                           rej_ff, rej_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]               held_ff, held_in;
   logic [ADDR_W-1:0]              slot_ff, slot_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic [SQ_W-1:0]                sqsum_ff, sqsum_in;
   logic signed [SAMPLE_BITS-1:0]  newest_ff, newest_in;
   logic [CNT_W-1:0]               window_ff, window_in;
   logic [sor_pkg::LIMIT_W-1:0]    limit_ff, limit_in;

   // working registers
   logic signed [SAMPLE_BITS-1:0]  x_ff, x_in;
   logic [MAG_W-1:0]               dm_ff, dm_in;
   logic [2*MAG_W-1:0]             dm2_ff, dm2_in;
   logic [NQ_W-1:0]                nq_ff, nq_in;
   logic [NQ_W-1:0]                var_ff, var_in;
   logic [sor_pkg::K2_W-1:0]       k2_ff, k2_in;
   logic [XSQ_W-1:0]               xsq_ff, xsq_in;
   logic [XSQ_W-1:0]               ovsq_ff, ovsq_in;
   logic signed [SAMPLE_BITS-1:0]  rsp_filtered_ff, rsp_filtered_in;
   logic                           rsp_rejected_ff, rsp_rejected_in;

   // sample ring
   logic [SAMPLE_BITS-1:0]         ring_mem [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0]  rd_data_ff;
   logic [ADDR_W-1:0]              old_addr;
   logic signed [OFS_W-1:0]        old_ofs;
   logic                           ring_we;

   // shared multiplier
   logic                           mul_start;
   logic [A_W-1:0]                 mul_a;
   logic [B_W-1:0]                 mul_b;
   logic [P_W-1:0]                 mul_prod;
   sor_pkg::mul_status_type        mul_stat;

   // helpers
   logic [SAMPLE_BITS-1:0]         x_mag;
   logic [SAMPLE_BITS-1:0]         ov_mag;
   logic [SUM_W-1:0]               sum_mag;
   logic                           evict;
   logic                           csr_write;
   logic                           req_beat;
   logic                           out_free;
   logic signed [DIFF_W-1:0]       nx_pos;
   logic signed [DIFF_W-1:0]       nx_dev;
   logic [CMP_W-1:0]               lhs_cmp;
   logic [WCMP_W-1:0]              win_raw;

   sor_mul_unit #(
      .A_W(A_W),
      .B_W(B_W),
      .P_W(P_W)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .status (mul_stat),
      .product(mul_prod)
   );

   // magnitudes, eviction and oldest slot
   always_comb begin
      x_mag   = x_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_ff) : SAMPLE_BITS'(x_ff);
      ov_mag  = rd_data_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rd_data_ff)
                                          : SAMPLE_BITS'(rd_data_ff);
      sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      evict   = (held_ff >= window_ff);
      old_ofs = signed'(OFS_W'(slot_ff)) - signed'(OFS_W'(held_ff));
      if (old_ofs < 0) begin
         old_ofs = old_ofs + signed'(OFS_W'(MAX_WINDOW));
      end
      old_addr = old_ofs[ADDR_W-1:0];
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_NX: begin
            mul_a = A_W'(x_mag);
            mul_b = B_W'(held_ff);
         end
         ST_DM2: begin
            mul_a = A_W'(dm_ff);
            mul_b = B_W'(dm_ff);
         end
         ST_NQ: begin
            mul_a = A_W'(sqsum_ff);
            mul_b = B_W'(held_ff);
         end
         ST_S2: begin
            mul_a = A_W'(sum_mag);
            mul_b = B_W'(sum_mag);
         end
         ST_K2: begin
            mul_a = A_W'(limit_ff);
            mul_b = B_W'(limit_ff);
         end
         ST_VK: begin
            mul_a = A_W'(var_ff);
            mul_b = B_W'(k2_ff);
         end
         ST_XX: begin
            mul_a = A_W'(x_mag);
            mul_b = B_W'(x_mag);
         end
         ST_OV: begin
            mul_a = A_W'(ov_mag);
            mul_b = B_W'(ov_mag);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_start = launch_ff && !(state_ff inside {ST_IDLE, ST_DONE});
   end

   // deviation n*x - S from the unsigned product, scaled left side and clamped window write value
   always_comb begin
      nx_pos  = signed'(DIFF_W'(mul_prod[SUM_W-1:0]));
      nx_dev  = x_ff[SAMPLE_BITS-1] ? (-nx_pos - DIFF_W'(sum_ff))
                                    : (nx_pos - DIFF_W'(sum_ff));
      lhs_cmp = CMP_W'(dm2_ff) << sor_pkg::VAR_SHIFT;
      win_raw = WCMP_W'(csr_wdata[sor_pkg::WINDOW_CFG_W-1:0]);
      if (win_raw == '0) begin
         win_raw = WCMP_W'(1);
      end else if (win_raw > WCMP_W'(MAX_WINDOW)) begin
         win_raw = WCMP_W'(MAX_WINDOW);
      end
   end

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_beat  = req_valid && req_ready;
   assign csr_write = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // sequencer and window update
   always_comb begin
      state_in        = state_ff;
      rej_in          = rej_ff;
      rsp_valid_in    = rsp_valid_ff;
      held_in         = held_ff;
      slot_in         = slot_ff;
      sum_in          = sum_ff;
      sqsum_in        = sqsum_ff;
      newest_in       = newest_ff;
      window_in       = window_ff;
      limit_in        = limit_ff;
      x_in            = x_ff;
      dm_in           = dm_ff;
      dm2_in          = dm2_ff;
      nq_in           = nq_ff;
      var_in          = var_ff;
      k2_in           = k2_ff;
      xsq_in          = xsq_ff;
      ovsq_in         = ovsq_ff;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_rejected_in = rsp_rejected_ff;
      ring_we         = 1'b0;

      // result beat taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_write) begin
         case (csr_index)
            sor_pkg::CSR_WINDOW_SIZE: begin
               window_in = CNT_W'(win_raw);
               held_in   = '0;
               slot_in   = '0;
               sum_in    = '0;
               sqsum_in  = '0;
               newest_in = '0;
            end
            sor_pkg::CSR_REJECT_LIMIT: begin
               limit_in = csr_wdata[sor_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               x_in   = req_sample;
               rej_in = 1'b0;
               state_in = (held_ff >= CNT_W'(sor_pkg::MIN_HELD)) ? ST_NX : ST_XX;
            end
         end
         ST_NX: begin
            if (mul_stat.done) begin
               dm_in    = (nx_dev < 0) ? MAG_W'(-nx_dev) : MAG_W'(nx_dev);
               state_in = ST_DM2;
            end
         end
         ST_DM2: begin
            if (mul_stat.done) begin
               dm2_in   = mul_prod[2*MAG_W-1:0];
               state_in = ST_NQ;
            end
         end
         ST_NQ: begin
            if (mul_stat.done) begin
               nq_in    = mul_prod[NQ_W-1:0];
               state_in = ST_S2;
            end
         end
         ST_S2: begin
            // zero variance: always keep
            if (mul_stat.done) begin
               if (P_W'(nq_ff) > mul_prod) begin
                  var_in   = nq_ff - mul_prod[NQ_W-1:0];
                  state_in = ST_K2;
               end else begin
                  state_in = ST_XX;
               end
            end
         end
         ST_K2: begin
            if (mul_stat.done) begin
               k2_in    = mul_prod[sor_pkg::K2_W-1:0];
               state_in = ST_VK;
            end
         end
         ST_VK: begin
            if (mul_stat.done) begin
               if (lhs_cmp > CMP_W'(mul_prod)) begin
                  rej_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_XX;
               end
            end
         end
         ST_XX: begin
            if (mul_stat.done) begin
               xsq_in   = mul_prod[XSQ_W-1:0];
               state_in = evict ? ST_OV : ST_DONE;
            end
         end
         ST_OV: begin
            if (mul_stat.done) begin
               ovsq_in  = mul_prod[XSQ_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the result beat, commit a kept sample
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_rejected_in = rej_ff;
               if (rej_ff) begin
                  rsp_filtered_in = newest_ff;
               end else begin
                  rsp_filtered_in = x_ff;
                  ring_we         = 1'b1;
                  newest_in       = x_ff;
                  slot_in = (slot_ff == ADDR_W'(MAX_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
                  if (evict) begin
                     sum_in   = sum_ff + SUM_W'(x_ff) - SUM_W'(rd_data_ff);
                     sqsum_in = sqsum_ff + SQ_W'(xsq_ff) - SQ_W'(ovsq_ff);
                  end else begin
                     sum_in   = sum_ff + SUM_W'(x_ff);
                     sqsum_in = sqsum_ff + SQ_W'(xsq_ff);
                     held_in  = held_ff + 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      launch_in = (state_in != state_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         newest_ff    <= '0;
         window_ff    <= CNT_W'(WINDOW_INIT);
         limit_ff     <= sor_pkg::LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         newest_ff    <= newest_in;
         window_ff    <= window_in;
         limit_ff     <= limit_in;
      end
   end

   // working and output registers
   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      dm_ff           <= dm_in;
      dm2_ff          <= dm2_in;
      nq_ff           <= nq_in;
      var_ff          <= var_in;
      k2_ff           <= k2_in;
      xsq_ff          <= xsq_in;
      ovsq_ff         <= ovsq_in;
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_rejected_ff <= rsp_rejected_in;
   end

   // sample ring, registered read of the oldest slot
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[slot_ff] <= x_ff;
      end
      rd_data_ff <= ring_mem[old_addr];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_rejected = rsp_rejected_ff;

   // checks
   a_held_in_window: assert property (@(posedge clock) disable iff (reset)
      held_ff <= window_ff)
      else $error("held count above window size");

   a_window_range: assert property (@(posedge clock) disable iff (reset)
      window_ff != '0 && window_ff <= CNT_W'(MAX_WINDOW))
      else $error("window size out of range");

   a_reject_repeats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rejected_ff |->
         rsp_filtered_ff == newest_ff && held_ff >= CNT_W'(sor_pkg::MIN_HELD))
      else $error("rejected beat does not repeat newest kept sample");

   a_idle_mul_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mul_stat.busy)
      else $error("multiplier busy while sequencer idle");

endmodule
